@@ rtl/core/mpfe_pkg.sv @@
// Shared types, codes and sizes for the mode page field editor.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package mpfe_pkg;

  localparam int PAGE_SIZE  = 256;
  localparam int PAGE_AW    = $clog2(PAGE_SIZE);
  localparam int NUM_BANKS  = 4;
  localparam int ROW_W      = PAGE_AW - 2;
  localparam int ROWS       = 1 << ROW_W;
  localparam int CMP_W      = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [2:0] CMD_LOAD_DATA = 3'd0;
  localparam logic [2:0] CMD_LOAD_MASK = 3'd1;
  localparam logic [2:0] CMD_SET       = 3'd2;
  localparam logic [2:0] CMD_AND       = 3'd3;
  localparam logic [2:0] CMD_OR        = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OFFSET = 3'd1;
  localparam logic [2:0] ST_WIDE   = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_LOCKED = 3'd4;

  typedef enum logic [1:0] {
    IK_DONE,
    IK_LOAD,
    IK_FIELD
  } item_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    item_kind_t  kind;
    logic [2:0]  status;
    logic [2:0]  cmd;
    logic [7:0]  offset;
    logic        bit_field;
    logic [2:0]  nbytes;
    logic [2:0]  shift;
    logic [31:0] fmask;
    logic [31:0] operand;
  } mpfe_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/mpfe_front.sv @@
// Front end: page_length register and request classification
// (offset, range and value-width checks, invert). Uses mpfe_pkg.
`default_nettype none
module mpfe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_write_en,
  input  wire logic [8:0]        cfg_page_length,
  input  wire logic [2:0]        in_command,
  input  wire logic [7:0]        in_offset,
  input  wire logic [2:0]        in_field_size,
  input  wire logic [2:0]        in_start_bit,
  input  wire logic [3:0]        in_bit_count,
  input  wire logic              in_invert,
  input  wire logic [31:0]       in_value,
  output mpfe_pkg::mpfe_item_t   item
);
  import mpfe_pkg::*;

  logic [8:0]       page_length_r;
  logic [8:0]       page_length_nxt;
  logic [2:0]       nbytes;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] off_w;
  logic [CMP_W-1:0] end_w;
  logic [31:0]      fmask;
  logic             is_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_length_r <= 9'd256;
    end else begin
      page_length_r <= page_length_nxt;
    end
  end

  always_comb begin
    page_length_nxt = cfg_write_en ? cfg_page_length : page_length_r;
  end

  always_comb begin
    nbytes = (in_field_size == 3'd0) ? 3'd1 : in_field_size;
    len    = (CMP_W'(page_length_r) > CMP_W'(PAGE_SIZE)) ? CMP_W'(PAGE_SIZE)
                                                          : CMP_W'(page_length_r);
    off_w  = CMP_W'(in_offset);
    end_w  = off_w + CMP_W'(nbytes);
    if (in_field_size == 3'd0) begin
      fmask = (in_bit_count >= 4'd8) ? 32'hFF : ((32'd1 << in_bit_count) - 32'd1);
    end else begin
      case (in_field_size)
        3'd1:    fmask = 32'hFF;
        3'd2:    fmask = 32'hFFFF;
        3'd3:    fmask = 32'hFFFFFF;
        default: fmask = 32'hFFFF_FFFF;
      endcase
    end
    is_load = in_command inside {CMD_LOAD_DATA, CMD_LOAD_MASK};

    item.kind      = IK_DONE;
    item.status    = ST_OK;
    item.cmd       = in_command;
    item.offset    = in_offset;
    item.bit_field = (in_field_size == 3'd0);
    item.nbytes    = nbytes;
    item.shift     = in_start_bit;
    item.fmask     = fmask;
    item.operand   = in_value;

    if (is_load) begin
      if (off_w >= CMP_W'(PAGE_SIZE)) begin
        item.status = ST_OFFSET;
      end else begin
        item.kind    = IK_LOAD;
        item.operand = {24'd0, in_value[7:0]};
      end
    end else if (in_command > CMD_READ) begin
      item.status = ST_OK;  // unknown code: empty answer
    end else if (off_w >= len || (in_field_size <= 3'd4 && end_w > len)) begin
      item.status = ST_OFFSET;
    end else if (in_field_size > 3'd4 ||
                 (in_field_size == 3'd0 &&
                  (in_bit_count > 4'd8 ||
                   5'(in_start_bit) + 5'(in_bit_count) > 5'd8))) begin
      item.status = ST_RANGE;
    end else if (in_command != CMD_READ && in_value > fmask) begin
      item.status = ST_WIDE;
    end else begin
      item.kind = IK_FIELD;
      if (in_invert && in_command != CMD_READ) begin
        item.operand = ~in_value & fmask;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/mpfe_fifo.sv @@
// Two-entry request queue between front and back end.
// Uses mpfe_pkg for the item and status types.
`default_nettype none
module mpfe_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mpfe_pkg::mpfe_item_t push_item,
  input  wire logic                 pop,
  output mpfe_pkg::mpfe_item_t      head_item,
  output mpfe_pkg::fifo_stat_t      stat
);
  import mpfe_pkg::*;

  mpfe_item_t  slot_r [FIFO_DEPTH];
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
    head_item  = slot_r[rd_ptr_r];
    stat.empty = (count_r == 2'd0);
    stat.full  = (count_r == 2'(FIFO_DEPTH));
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 2'd1)
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

@@ rtl/core/mpfe_back.sv @@
// Back end: byte-banked page and mask memories, read-modify-write of
// fields and loads, result register. Uses mpfe_pkg.
`default_nettype none
module mpfe_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mpfe_pkg::mpfe_item_t head_item,
  input  wire mpfe_pkg::fifo_stat_t fifo_stat,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [2:0]                out_status,
  output logic [31:0]               out_old_value,
  output logic [31:0]               out_new_value
);
  import mpfe_pkg::*;

  logic [7:0]       page_mem [NUM_BANKS][ROWS];
  logic [7:0]       mask_mem [NUM_BANKS][ROWS];
  logic [7:0]       page_rd_r [NUM_BANKS];
  logic [7:0]       mask_rd_r [NUM_BANKS];

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic             out_strobe_r;
  logic             out_strobe_nxt;
  logic [2:0]       out_status_r;
  logic [2:0]       out_status_nxt;
  logic [31:0]      out_old_r;
  logic [31:0]      out_old_nxt;
  logic [31:0]      out_new_r;
  logic [31:0]      out_new_nxt;

  logic [1:0]       bank_idx [NUM_BANKS];
  logic [ROW_W-1:0] row      [NUM_BANKS];
  logic [CMP_W-1:0] addr     [NUM_BANKS];
  logic [7:0]       page_byte [NUM_BANKS];
  logic [7:0]       mask_byte [NUM_BANKS];
  logic [7:0]       wbyte     [NUM_BANKS];
  logic             page_we  [NUM_BANKS];
  logic             mask_we  [NUM_BANKS];
  logic [7:0]       wdata    [NUM_BANKS];
  logic [31:0]      be_page;
  logic [31:0]      be_mask;
  logic [31:0]      old_v;
  logic [31:0]      cm_v;
  logic [31:0]      new_v;
  logic [31:0]      aligned;
  logic [7:0]       bm;
  logic [7:0]       bit_byte;
  logic             is_mask;
  logic             do_write;
  logic [2:0]       res_status;
  logic [31:0]      res_old;
  logic [31:0]      res_new;

  // Byte i of the field (i = 0 most significant) lives in bank offset+i.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_idx[b] = 2'(2'(b) - head_item.offset[1:0]);
      addr[b]     = CMP_W'(head_item.offset) + CMP_W'(bank_idx[b]);
      row[b]      = addr[b][PAGE_AW-1:2];
    end
    for (int i = 0; i < NUM_BANKS; i++) begin
      page_byte[i] = page_rd_r[2'(head_item.offset[1:0] + 2'(i))];
      mask_byte[i] = mask_rd_r[2'(head_item.offset[1:0] + 2'(i))];
    end
    be_page = {page_byte[0], page_byte[1], page_byte[2], page_byte[3]};
    be_mask = {mask_byte[0], mask_byte[1], mask_byte[2], mask_byte[3]};
  end

  // Field evaluation
  always_comb begin
    if (head_item.bit_field) begin
      old_v = 32'(page_byte[0] >> head_item.shift) & head_item.fmask;
      cm_v  = 32'(mask_byte[0] >> head_item.shift) & head_item.fmask;
    end else begin
      case (head_item.nbytes)
        3'd1:    begin old_v = be_page >> 24; cm_v = be_mask >> 24; end
        3'd2:    begin old_v = be_page >> 16; cm_v = be_mask >> 16; end
        3'd3:    begin old_v = be_page >> 8;  cm_v = be_mask >> 8;  end
        default: begin old_v = be_page;       cm_v = be_mask;       end
      endcase
    end

    case (head_item.cmd)
      CMD_SET: new_v = head_item.operand;
      CMD_AND: new_v = old_v & head_item.operand;
      default: new_v = old_v | head_item.operand;
    endcase
    new_v = new_v & head_item.fmask;

    bm       = 8'(head_item.fmask << head_item.shift);
    bit_byte = (page_byte[0] & ~bm) | (8'(new_v << head_item.shift) & bm);

    if (head_item.bit_field) begin
      aligned = {bit_byte, 24'd0};
    end else begin
      case (head_item.nbytes)
        3'd1:    aligned = new_v << 24;
        3'd2:    aligned = new_v << 16;
        3'd3:    aligned = new_v << 8;
        default: aligned = new_v;
      endcase
    end
    for (int i = 0; i < NUM_BANKS; i++) begin
      wbyte[i] = aligned[31 - 8 * i -: 8];
    end

    is_mask  = (head_item.cmd == CMD_LOAD_MASK);
    do_write = 1'b0;
    if (head_item.kind == IK_LOAD) begin
      res_status = ST_OK;
      res_old    = {24'd0, is_mask ? mask_byte[0] : page_byte[0]};
      res_new    = head_item.operand;
    end else if (head_item.cmd == CMD_READ) begin
      res_status = ST_OK;
      res_old    = old_v;
      res_new    = old_v;
    end else if (cm_v == 32'd0) begin
      res_status = ST_LOCKED;
      res_old    = old_v;
      res_new    = old_v;
    end else begin
      res_status = ST_OK;
      res_old    = old_v;
      res_new    = new_v;
      do_write   = 1'b1;
    end
  end

  // Write ports, active only in the execute cycle
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (head_item.kind == IK_LOAD) begin
        wdata[b]   = head_item.operand[7:0];
        page_we[b] = (state_r == BK_EXEC) && !is_mask && (bank_idx[b] == 2'd0);
        mask_we[b] = (state_r == BK_EXEC) && is_mask && (bank_idx[b] == 2'd0);
      end else begin
        wdata[b]   = wbyte[bank_idx[b]];
        page_we[b] = (state_r == BK_EXEC) && do_write &&
                     (3'(bank_idx[b]) < head_item.nbytes);
        mask_we[b] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (page_we[b]) begin
        page_mem[b][row[b]] <= wdata[b];
      end
      if (mask_we[b]) begin
        mask_mem[b][row[b]] <= wdata[b];
      end
      page_rd_r[b] <= page_mem[b][row[b]];
      mask_rd_r[b] <= mask_mem[b][row[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_old_r    <= out_old_nxt;
    out_new_r    <= out_new_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pop            = 1'b0;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_old_nxt    = out_old_r;
    out_new_nxt    = out_new_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          if (head_item.kind == IK_DONE) begin
            pop            = 1'b1;
            out_strobe_nxt = 1'b1;
            out_status_nxt = head_item.status;
            out_old_nxt    = 32'd0;
            out_new_nxt    = 32'd0;
          end else begin
            state_nxt = BK_EXEC;  // memory read issued this cycle
          end
        end
      end
      BK_EXEC: begin
        pop            = 1'b1;
        out_strobe_nxt = 1'b1;
        out_status_nxt = res_status;
        out_old_nxt    = res_old;
        out_new_nxt    = res_new;
        state_nxt      = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_old_value = out_old_r;
  assign out_new_value = out_new_r;

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> state_r == BK_IDLE)
    else $error("execute state held");

  a_exec_answers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> out_strobe_r)
    else $error("execute cycle gave no result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ rtl/core/mode_page_field_editor_unit.sv @@
// Top level of the mode page field editor: front end, request queue and
// back end. Depends on mpfe_pkg, mpfe_front, mpfe_fifo and mpfe_back.
//
// Usage
//   Requests: drive in_* and raise start; a request is taken at a clock
//   edge where start is high and busy is low. busy is high while the
//   two-entry request queue is full.
//   Results: one result per request, in request order, shown for exactly
//   one cycle with out_strobe high. The receiver cannot stall; results are
//   never held back.
//   Config: cfg_write_en with cfg_page_length writes page_length; write it
//   only while no request is in flight.
// Timing
//   Loads and field requests pass the back-end states idle, which issues
//   the banked memory read, and execute, which does modify, write-back and
//   result. No request leaves the queue before the current one has its
//   result; the queue accepts requests until full. Rejected and unknown
//   requests are answered from idle with no memory read. out_strobe follows
//   the queue, memory read and result registers; rejected ones skip the read.
// Reset
//   rst_n is synchronous, active low. It empties the queue, idles the back
//   end and sets page_length to 256. Page and mask contents are undefined
//   until loaded; there is no clearing pass.
`default_nettype none
module mode_page_field_editor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic [8:0]  cfg_page_length,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_offset,
  input  wire logic [2:0]  in_field_size,
  input  wire logic [2:0]  in_start_bit,
  input  wire logic [3:0]  in_bit_count,
  input  wire logic        in_invert,
  input  wire logic [31:0] in_value,
  // result channel
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [31:0]      out_old_value,
  output logic [31:0]      out_new_value
);
  import mpfe_pkg::*;

  mpfe_item_t front_item;
  mpfe_item_t head_item;
  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;

  // Classification is combinational; the queue register is the boundary.
  mpfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_page_length (cfg_page_length),
    .in_command      (in_command),
    .in_offset       (in_offset),
    .in_field_size   (in_field_size),
    .in_start_bit    (in_start_bit),
    .in_bit_count    (in_bit_count),
    .in_invert       (in_invert),
    .in_value        (in_value),
    .item            (front_item)
  );

  assign busy = fifo_stat.full;
  assign push = start && !busy;

  mpfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (fifo_stat)
  );

  // Back end owns the banked memories and the result register.
  mpfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (head_item),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_old_value (out_old_value),
    .out_new_value (out_new_value)
  );

endmodule
`default_nettype wire

@@ tb/mode_page_field_checker.sv @@
// Scoreboard for the mode page field editor: predicts each request's result.
// Depends on mpfe_pkg for the command and status codes and PAGE_SIZE.
module mode_page_field_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [8:0]  cfg_page_length,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_offset,
  input  wire logic [2:0]  in_field_size,
  input  wire logic [2:0]  in_start_bit,
  input  wire logic [3:0]  in_bit_count,
  input  wire logic        in_invert,
  input  wire logic [31:0] in_value,
  input  wire logic        out_strobe,
  input  wire logic [2:0]  out_status,
  input  wire logic [31:0] out_old_value,
  input  wire logic [31:0] out_new_value,
  output int               error_count,
  output int               pending_count
);
  import mpfe_pkg::*;

  localparam logic [2:0] FS_BIT_RANGE = 3'd0;
  localparam logic [2:0] FS_MAX_BYTES = 3'd4;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] old_value;
    logic [31:0] new_value;
    bit          old_known;  // first load of a byte returns an undefined old byte
  } field_result_t;

  logic [7:0]    page_image [PAGE_SIZE];
  logic [7:0]    mask_image [PAGE_SIZE];
  bit            page_written [PAGE_SIZE];
  bit            mask_written [PAGE_SIZE];
  logic [8:0]    page_length_q;
  field_result_t expected_results [$];

  function automatic field_result_t predict_field_result(
    input logic [2:0] cmd, input logic [7:0] off, input logic [2:0] fsz,
    input logic [2:0] sbit, input logic [3:0] nbits, input logic inv,
    input logic [31:0] val);
    field_result_t r;
    int            len;
    int            nbytes;
    logic [63:0]   wide_mask;
    logic [31:0]   fmask;
    logic [31:0]   oldv;
    logic [31:0]   cm;
    logic [31:0]   operand;
    logic [31:0]   newv;
    logic [7:0]    bm;
    r = '{ST_OK, 32'd0, 32'd0, 1'b1};
    if (cmd == CMD_LOAD_DATA || cmd == CMD_LOAD_MASK) begin
      // loads ignore page_length; an 8-bit offset is always inside the page
      if (cmd == CMD_LOAD_DATA) begin
        r.old_value = {24'd0, page_image[off]};
        r.old_known = page_written[off];
        page_image[off] = val[7:0];
        page_written[off] = 1'b1;
      end else begin
        r.old_value = {24'd0, mask_image[off]};
        r.old_known = mask_written[off];
        mask_image[off] = val[7:0];
        mask_written[off] = 1'b1;
      end
      r.new_value = {24'd0, val[7:0]};
      return r;
    end
    if (cmd > CMD_READ) return r;

    len = (page_length_q > PAGE_SIZE) ? PAGE_SIZE : int'(page_length_q);
    nbytes = (fsz == FS_BIT_RANGE) ? 1 : int'(fsz);
    if (int'(off) >= len || (fsz <= FS_MAX_BYTES && int'(off) + nbytes > len)) begin
      r.status = ST_OFFSET;
      return r;
    end
    if (fsz > FS_MAX_BYTES ||
        (fsz == FS_BIT_RANGE && (nbits > 8 || int'(sbit) + int'(nbits) > 8))) begin
      r.status = ST_RANGE;
      return r;
    end

    if (fsz == FS_BIT_RANGE) begin
      wide_mask = (64'd1 << nbits) - 64'd1;
      fmask = wide_mask[31:0];
      oldv = ({24'd0, page_image[off]} >> sbit) & fmask;
      cm = ({24'd0, mask_image[off]} >> sbit) & fmask;
    end else begin
      wide_mask = (64'd1 << (8 * nbytes)) - 64'd1;
      fmask = wide_mask[31:0];
      oldv = '0;
      cm = '0;
      for (int i = 0; i < nbytes; i++) begin
        oldv = (oldv << 8) | page_image[int'(off) + i];
        cm = (cm << 8) | mask_image[int'(off) + i];
      end
    end

    if (cmd == CMD_READ) begin
      r.old_value = oldv;
      r.new_value = oldv;
      return r;
    end
    if (val > fmask) begin
      r.status = ST_WIDE;
      return r;
    end
    operand = inv ? (~val & fmask) : val;
    if (cm == '0) begin
      r = '{ST_LOCKED, oldv, oldv, 1'b1};
      return r;
    end

    case (cmd)
      CMD_SET: newv = operand;
      CMD_AND: newv = oldv & operand;
      default: newv = oldv | operand;
    endcase
    newv &= fmask;

    if (fsz == FS_BIT_RANGE) begin
      bm = fmask[7:0] << sbit;
      page_image[off] = (page_image[off] & ~bm) | ((newv[7:0] << sbit) & bm);
    end else begin
      for (int i = 0; i < nbytes; i++)
        page_image[int'(off) + nbytes - 1 - i] = newv[8 * i +: 8];
    end
    r = '{ST_OK, oldv, newv, 1'b1};
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $error("%s mismatch: expected 0x%08h, got 0x%08h", field, want, got);
  endtask

  // result first: it belongs to an older request than one taken at this edge
  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      page_length_q = 9'd256;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $error("result strobe with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", {29'd0, want.status}, {29'd0, out_status});
          if (want.old_known && out_old_value !== want.old_value)
            report_mismatch("old_value", want.old_value, out_old_value);
          if (out_new_value !== want.new_value)
            report_mismatch("new_value", want.new_value, out_new_value);
        end
      end
      if (cfg_write_en)
        page_length_q = cfg_page_length;
      if (start && !busy)
        expected_results.push_back(predict_field_result(in_command, in_offset,
          in_field_size, in_start_bit, in_bit_count, in_invert, in_value));
    end
    pending_count = expected_results.size();
  end

endmodule

@@ tb/mode_page_field_editor_unit_test.sv @@
// Top of the field editor testbench: clock, reset, request stimulus, verdict.
// Depends on mpfe_pkg, mode_page_field_editor_unit and mode_page_field_checker.
module mode_page_field_editor_unit_test;
  import mpfe_pkg::*;

  // command codes the block answers as no-ops
  localparam logic [2:0] CMD_RSVD_LO  = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;
  // field_size codes: 0 is a bit range, 1..4 byte counts, 5..7 illegal
  localparam logic [2:0] FS_BIT_RANGE = 3'd0;
  localparam logic [2:0] FS_MAX_BYTES = 3'd4;
  localparam logic [2:0] FS_BAD_LO    = 3'd5;
  localparam logic [2:0] FS_BAD_HI    = 3'd7;

  localparam int ITEMS_PER_PHASE = 135;
  localparam int PHASES          = 8;
  localparam int QUIET_FIRST     = 400;  // random items in [QUIET_FIRST, QUIET_LAST)
  localparam int QUIET_LAST      = 700;  // are sent back to back
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int RUN_LIMIT       = 400000;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  off;
    logic [2:0]  fsz;
    logic [2:0]  sbit;
    logic [3:0]  nbits;
    logic        inv;
    logic [31:0] val;
  } field_request_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_write_en    = 1'b0;
  logic [8:0]  cfg_page_length = 9'd256;
  logic        start           = 1'b0;
  logic        busy;
  logic [2:0]  in_command      = CMD_LOAD_DATA;
  logic [7:0]  in_offset       = 8'd0;
  logic [2:0]  in_field_size   = FS_BIT_RANGE;
  logic [2:0]  in_start_bit    = 3'd0;
  logic [3:0]  in_bit_count    = 4'd0;
  logic        in_invert       = 1'b0;
  logic [31:0] in_value        = 32'd0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_old_value;
  logic [31:0] out_new_value;
  int          error_count;
  int          pending_count;
  int          page_length_now = 256;

  // page_length settings walked by the random phases: reset value, the 9-bit
  // maximum (acts as the full page), empty page, a single byte, lengths between and 300 (above the page)
  logic [8:0] length_plan [PHASES] = '{9'd256, 9'd511, 9'd0, 9'd1,
                                       9'd200, 9'd255, 9'd300, 9'd17};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mode_page_field_editor_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_page_length (cfg_page_length),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_offset       (in_offset),
    .in_field_size   (in_field_size),
    .in_start_bit    (in_start_bit),
    .in_bit_count    (in_bit_count),
    .in_invert       (in_invert),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_old_value   (out_old_value),
    .out_new_value   (out_new_value)
  );

  mode_page_field_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_page_length (cfg_page_length),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_offset       (in_offset),
    .in_field_size   (in_field_size),
    .in_start_bit    (in_start_bit),
    .in_bit_count    (in_bit_count),
    .in_invert       (in_invert),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_old_value   (out_old_value),
    .out_new_value   (out_new_value),
    .error_count     (error_count),
    .pending_count   (pending_count)
  );

  function automatic field_request_t mk(
    input logic [2:0] cmd, input logic [7:0] off, input logic [2:0] fsz,
    input logic [2:0] sbit, input logic [3:0] nbits, input logic inv,
    input logic [31:0] val);
    field_request_t r;
    r = '{cmd, off, fsz, sbit, nbits, inv, val};
    return r;
  endfunction

  // Mostly well-formed field requests that land inside the current page, with
  // a sprinkling of bad sizes, bad bit ranges, stray offsets and wide values.
  function automatic field_request_t make_random_request(input int eff_len);
    field_request_t r;
    int             pick;
    int             nb;
    logic [63:0]    width_mask;
    logic [31:0]    vmask;
    pick = $urandom_range(0, 99);
    r.inv = 1'($urandom_range(0, 1));
    r.fsz = 3'($urandom_range(0, 4));
    r.nbits = 4'($urandom_range(0, 8));
    r.sbit = 3'($urandom_range(0, 7));
    if (pick < 12)      r.cmd = CMD_LOAD_DATA;
    else if (pick < 22) r.cmd = CMD_LOAD_MASK;
    else if (pick < 45) r.cmd = CMD_SET;
    else if (pick < 62) r.cmd = CMD_AND;
    else if (pick < 79) r.cmd = CMD_OR;
    else if (pick < 96) r.cmd = CMD_READ;
    else                r.cmd = $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;

    // broken field descriptors now and then
    if ($urandom_range(0, 19) == 0) r.fsz = 3'($urandom_range(FS_BAD_LO, FS_BAD_HI));
    if ($urandom_range(0, 19) == 0) r.nbits = 4'($urandom_range(9, 15));
    if (r.nbits <= 8 && $urandom_range(0, 4) != 0)
      r.sbit = 3'($urandom_range(0, 8 - r.nbits));

    nb = (r.fsz == FS_BIT_RANGE || r.fsz > FS_MAX_BYTES) ? 1 : int'(r.fsz);
    if (r.cmd != CMD_LOAD_DATA && r.cmd != CMD_LOAD_MASK && eff_len >= nb &&
        $urandom_range(0, 99) < 85)
      r.off = 8'($urandom_range(0, eff_len - nb));
    else
      r.off = 8'($urandom_range(0, 255));

    if (r.fsz == FS_BIT_RANGE)
      width_mask = (64'd1 << ((r.nbits > 8) ? 8 : r.nbits)) - 64'd1;
    else if (r.fsz <= FS_MAX_BYTES)
      width_mask = (64'd1 << (8 * int'(r.fsz))) - 64'd1;
    else
      width_mask = 64'hFF;
    vmask = width_mask[31:0];

    pick = $urandom_range(0, 9);
    if (r.cmd == CMD_LOAD_MASK)
      // locked bytes must be common enough to matter, fully open ones too
      r.val = (pick < 3) ? {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'h00} :
              (pick < 5) ? 32'hFFFF_FFFF : $urandom;
    else if (pick < 7) r.val = $urandom & vmask;
    else if (pick < 8) r.val = vmask;
    else if (pick < 9) r.val = 32'd0;
    else               r.val = $urandom;
    return r;
  endfunction

  // Holds the request until the block takes it; start stays high on return.
  task automatic send_request(input field_request_t r);
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= r.cmd;
    in_offset     <= r.off;
    in_field_size <= r.fsz;
    in_start_bit  <= r.sbit;
    in_bit_count  <= r.nbits;
    in_invert     <= r.inv;
    in_value      <= r.val;
    do @(posedge clk); while (busy);
  endtask

  // Each cycle after a request idles with a one-in-three chance, so about a
  // third of the cycles carry no request.
  task automatic maybe_idle();
    while ($urandom_range(0, 99) < 33) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic settle_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // page_length only changes while nothing is in flight
  task automatic program_length(input logic [8:0] len);
    settle_results();
    cfg_write_en    <= 1'b1;
    cfg_page_length <= len;
    @(negedge clk);
    cfg_write_en    <= 1'b0;
    page_length_now = (len > PAGE_SIZE) ? PAGE_SIZE : int'(len);
  endtask

  initial begin
    field_request_t directed [$];
    int             random_no;
    random_no = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    program_length(9'd256);

    // Fill both pages so no field request ever reads an unloaded byte.
    // Data bytes carry junk in the upper value bits; roughly one mask byte in
    // eight is zero so locked fields show up later.
    for (int a = 0; a < PAGE_SIZE; a++) begin
      send_request(mk(CMD_LOAD_DATA, 8'(a), FS_BIT_RANGE, 3'd0, 4'd0, 1'b0, $urandom));
      maybe_idle();
    end
    for (int a = 0; a < PAGE_SIZE; a++) begin
      send_request(mk(CMD_LOAD_MASK, 8'(a), FS_BIT_RANGE, 3'd0, 4'd0, 1'b0,
                      ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom));
      maybe_idle();
    end

    // directed corners at full page length
    directed.push_back(mk(CMD_READ, 8'd252, 3'd4, 3'd0, 4'd0, 1'b0, 32'd0));  // ends on last byte
    directed.push_back(mk(CMD_READ, 8'd253, 3'd4, 3'd0, 4'd0, 1'b0, 32'd0));  // runs off the page
    directed.push_back(mk(CMD_LOAD_MASK, 8'd30, FS_BIT_RANGE, 3'd0, 4'd0, 1'b0, 32'd0));
    directed.push_back(mk(CMD_SET, 8'd30, 3'd1, 3'd0, 4'd0, 1'b0, 32'h5A));    // locked byte
    directed.push_back(mk(CMD_LOAD_MASK, 8'd30, FS_BIT_RANGE, 3'd7, 4'd15, 1'b1,
                          32'hFFFF_FFFF));
    directed.push_back(mk(CMD_SET, 8'd30, 3'd1, 3'd0, 4'd0, 1'b0, 32'h5A));
    directed.push_back(mk(CMD_SET, 8'd0, 3'd1, 3'd0, 4'd0, 1'b0, 32'h100));    // too wide
    directed.push_back(mk(CMD_SET, 8'd0, 3'd1, 3'd0, 4'd0, 1'b1, 32'hFF));
    directed.push_back(mk(CMD_SET, 8'd100, 3'd4, 3'd0, 4'd0, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_OR, 8'd100, 3'd4, 3'd0, 4'd0, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_AND, 8'd10, 3'd2, 3'd0, 4'd0, 1'b0, 32'h0000_F0F0));
    directed.push_back(mk(CMD_SET, 8'd10, 3'd2, 3'd0, 4'd0, 1'b0, 32'h0001_0000));
    directed.push_back(mk(CMD_OR, 8'd20, 3'd3, 3'd0, 4'd0, 1'b0, 32'h00FF_FFFF));
    directed.push_back(mk(CMD_SET, 8'd40, FS_BIT_RANGE, 3'd7, 4'd1, 1'b0, 32'd1));
    directed.push_back(mk(CMD_SET, 8'd40, FS_BIT_RANGE, 3'd0, 4'd8, 1'b1, 32'h0F));
    // empty bit field: nothing changeable, read gives zero whatever the value
    directed.push_back(mk(CMD_SET, 8'd40, FS_BIT_RANGE, 3'd3, 4'd0, 1'b0, 32'd0));
    directed.push_back(mk(CMD_READ, 8'd40, FS_BIT_RANGE, 3'd3, 4'd0, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_SET, 8'd40, FS_BIT_RANGE, 3'd0, 4'd9, 1'b0, 32'd0));
    directed.push_back(mk(CMD_AND, 8'd40, FS_BIT_RANGE, 3'd5, 4'd4, 1'b0, 32'd0));
    directed.push_back(mk(CMD_OR, 8'd40, FS_BIT_RANGE, 3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_SET, 8'd40, FS_BAD_LO, 3'd0, 4'd0, 1'b0, 32'd0));
    directed.push_back(mk(CMD_READ, 8'd40, FS_BAD_HI, 3'd0, 4'd0, 1'b0, 32'd0));
    directed.push_back(mk(CMD_RSVD_LO, 8'd255, FS_BAD_HI, 3'd7, 4'd15, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_RSVD_HI, 8'd0, FS_BIT_RANGE, 3'd0, 4'd0, 1'b0, 32'd0));
    directed.push_back(mk(CMD_LOAD_DATA, 8'd255, FS_BIT_RANGE, 3'd0, 4'd0, 1'b0,
                          32'hFFFF_FF00));
    foreach (directed[i]) begin
      send_request(directed[i]);
      maybe_idle();
    end

    // Random phases, one page_length setting each. Every phase boundary
    // drains the block completely before the register is touched.
    for (int ph = 0; ph < PHASES; ph++) begin
      program_length(length_plan[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_request(make_random_request(page_length_now));
        if (random_no < QUIET_FIRST || random_no >= QUIET_LAST)
          maybe_idle();
        random_no++;
      end
    end

    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #RUN_LIMIT;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mpfe_pkg.sv
rtl/core/mpfe_front.sv
rtl/core/mpfe_fifo.sv
rtl/core/mpfe_back.sv
rtl/core/mode_page_field_editor_unit.sv
tb/mode_page_field_checker.sv
tb/mode_page_field_editor_unit_test.sv
